// ===== design/pidrac_pkg.sv =====
package pidrac_pkg;

	// defaults for the top level parameters
	localparam int DataWidthDef = 32;
	localparam int FracBitsDef  = 16;

	// multiplier digit handled per step of the shared unit
	localparam int MulDigitW = 4;

	// configuration register indexes
	localparam int CfgAddrW = 3;
	typedef enum logic [CfgAddrW-1:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_LIMIT_LOW  = 3'd3,
		REG_LIMIT_HIGH = 3'd4
	} cfg_reg_t;

	// op field of an input word
	typedef enum logic [0:0] {
		OP_COMPUTE = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	// operation of the shared multiply/divide unit
	typedef enum logic [0:0] {
		MODE_MUL = 1'b0,
		MODE_DIV = 1'b1
	} mode_t;

	typedef struct packed {
		logic  start;
		mode_t mode;
	} muldiv_ctrl_t;

endpackage

// ===== design/pidrac_muldiv.sv =====
module pidrac_muldiv #(
	parameter int W = pidrac_pkg::DataWidthDef,
	parameter int F = pidrac_pkg::FracBitsDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pidrac_pkg::muldiv_ctrl_t  ctrl,
	input  logic [W-1:0]              op_a,   // multiplicand or numerator, signed
	input  logic [W-1:0]              op_b,   // multiplier or positive divisor
	output logic                      done,
	output logic [W-1:0]              res     // saturated signed result
);
	import pidrac_pkg::*;

	localparam int NDig = (W + MulDigitW - 1) / MulDigitW;
	localparam int BPad = NDig * MulDigitW;
	localparam int DivN = W + F;
	localparam int AccW = (2 * W > DivN) ? 2 * W : DivN;
	localparam int CntW = $clog2(DivN + 1);

	function automatic logic [W-1:0] abs_mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
	endfunction

	mode_t            mode_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [CntW-1:0]  cnt_q;
	logic [W-1:0]     a_q;
	logic [BPad-1:0]  b_q;
	logic [AccW-1:0]  acc_q;
	logic [W-1:0]     rem_q;

	logic [W+MulDigitW-1:0] pp;
	logic [W:0]             rem_sh;
	logic                   ge;
	logic [AccW-1:0]        mag_full;
	logic [AccW-1:0]        lim;
	logic [W-1:0]           mag_sat;

	assign pp     = a_q * b_q[BPad-1 -: MulDigitW];
	assign rem_sh = {rem_q, acc_q[DivN-1]};
	assign ge     = rem_sh >= {1'b0, a_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= (ctrl.mode == MODE_DIV) ? CntW'(DivN) : CntW'(NDig);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CntW'(1);
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			mode_q <= ctrl.mode;
			rem_q  <= '0;
			if (ctrl.mode == MODE_DIV) begin
				neg_q <= op_a[W-1];
				a_q   <= op_b;
				acc_q <= AccW'(abs_mag(op_a)) << F;
			end else begin
				neg_q <= op_a[W-1] ^ op_b[W-1];
				a_q   <= abs_mag(op_a);
				b_q   <= BPad'(abs_mag(op_b));
				acc_q <= '0;
			end
		end else if (busy_q) begin
			if (mode_q == MODE_DIV) begin
				// restoring step, quotient bits enter at the bottom
				acc_q <= {acc_q[AccW-2:0], ge};
				rem_q <= ge ? W'(rem_sh - {1'b0, a_q}) : rem_sh[W-1:0];
			end else begin
				// one digit of the multiplier, most significant first
				acc_q <= (acc_q << MulDigitW) + AccW'(pp);
				b_q   <= b_q << MulDigitW;
			end
		end
	end

	always_comb begin
		if (mode_q == MODE_DIV) begin
			mag_full = AccW'(acc_q[DivN-1:0]);
		end else begin
			mag_full = acc_q >> F;
		end
		lim     = AccW'({1'b0, {(W-1){1'b1}}}) + AccW'(neg_q);
		mag_sat = (mag_full > lim) ? lim[W-1:0] : mag_full[W-1:0];
		res     = neg_q ? (~mag_sat + {{(W-1){1'b0}}, 1'b1}) : mag_sat;
	end

	assign done = done_q;

endmodule

// ===== design/pid_reverse_acting_controller.sv =====
// sequence: a compute word runs through the shared multiply/divide unit, four multiplies
//   (4 bits a cycle) and one divide (1 bit a cycle) in turn, then sums and clamps; a
//   priming or restart word goes straight to the output state; a new input word is taken
//   only after the last one has been passed to the output register
// reset: asynchronous active low; gains and low limit clear, high limit 100.0,
//   integral and previous measurement clear, the next compute word only primes
module pid_reverse_acting_controller #(
	parameter int DATA_WIDTH = pidrac_pkg::DataWidthDef,
	parameter int FRAC_BITS  = pidrac_pkg::FracBitsDef
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [pidrac_pkg::CfgAddrW-1:0]    cfg_addr,
	input  logic [DATA_WIDTH-1:0]              cfg_wdata,
	// input words
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// target, measured, step_time, elapsed_time (lowest bits first), zero pad
	input  logic [((4*DATA_WIDTH-1+7)/8)*8-1:0] s_axis_tdata,
	// op
	input  logic [0:0]                         s_axis_tuser,
	// result words
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// drive, zero pad
	output logic [((DATA_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
	// priming
	output logic [0:0]                         m_axis_tuser
);
	import pidrac_pkg::*;

	localparam int W      = DATA_WIDTH;
	localparam int OutW   = ((W + 7) / 8) * 8;
	localparam int OneQ   = 1 << FRAC_BITS;
	// 0.001 s rounded to the nearest code, at least one code
	localparam int MinDtRaw = (OneQ + 500) / 1000;
	localparam int MinDt    = (MinDtRaw > 0) ? MinDtRaw : 1;
	localparam logic [W-2:0] MinDtV = (W-1)'(MinDt);
	// 100.0 for the high limit at reset
	localparam logic [W-1:0] LimHighRst = W'(100 * OneQ);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MUL_P = 9'b000000010,
		ST_MUL_I = 9'b000000100,
		ST_MUL_T = 9'b000001000,
		ST_INTEG = 9'b000010000,
		ST_DIV_R = 9'b000100000,
		ST_MUL_D = 9'b001000000,
		ST_SUM   = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	// difference of two signed values, saturated to the data range
	function automatic logic [W-1:0] sat_diff(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] d;
		d = {a[W-1], a} - {b[W-1], b};
		if (d[W] != d[W-1]) begin
			return d[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end
		return d[W-1:0];
	endfunction

	// low limit wins first, then the high limit; with inverted limits the result is always one of the two limits
	function automatic logic [W-1:0] clamp_lim(input logic signed [W+1:0] x,
			input logic signed [W-1:0] lo, input logic signed [W-1:0] hi);
		logic signed [W+1:0] lo_x;
		logic signed [W+1:0] hi_x;
		logic signed [W+1:0] r;
		lo_x = lo;
		hi_x = hi;
		if (x < lo_x) begin
			r = lo_x;
		end else if (x > hi_x) begin
			r = hi_x;
		end else begin
			r = x;
		end
		return r[W-1:0];
	endfunction

	// configuration registers
	logic [W-1:0] gain_p_q, gain_i_q, gain_d_q, lim_lo_q, lim_hi_q;

	// controller state
	logic [W-1:0] integ_q;
	logic [W-1:0] prev_q;
	logic         first_q;

	// sequencer
	state_t state_q;
	logic   start_q;
	logic   prime_q;

	// operands captured at acceptance and intermediate terms
	logic [W-1:0] err_q;    // measured - target
	logic [W-1:0] diff_q;   // measured - previous measured
	logic [W-1:0] dt_q;     // floored time step, positive
	logic [W-1:0] p_q;      // proportional term
	logic [W-1:0] t_q;      // running temp: ki*err, increment, rate, derivative term
	logic [W-1:0] sum_q;

	// output register
	logic         m_valid_q;
	logic [W-1:0] m_drive_q;
	logic         m_prime_q;

	// input word fields
	logic [W-1:0] in_target, in_measured, in_step;
	logic [W-2:0] in_elapsed;
	op_t          in_op;

	logic         accept;
	logic         out_free;
	logic         step_pos;
	logic [W-2:0] dt_sel;
	logic [W-2:0] dt_fl;

	muldiv_ctrl_t unit_ctrl;
	logic [W-1:0] unit_a, unit_b, unit_res;
	logic         unit_done;

	logic signed [W+1:0] integ_x;
	logic signed [W+1:0] sum_x;
	logic [W-1:0]        lo_new, hi_new;

	assign in_target   = s_axis_tdata[W-1:0];
	assign in_measured = s_axis_tdata[2*W-1:W];
	assign in_step     = s_axis_tdata[3*W-1:2*W];
	assign in_elapsed  = s_axis_tdata[4*W-2:3*W];
	assign in_op       = op_t'(s_axis_tuser[0]);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// caller step when positive, else elapsed time, then floor at 1 ms
	assign step_pos = !in_step[W-1] && (in_step != '0);
	assign dt_sel   = step_pos ? in_step[W-2:0] : in_elapsed;
	assign dt_fl    = (dt_sel < MinDtV) ? MinDtV : dt_sel;

	// operand selection for the shared unit
	always_comb begin
		unit_ctrl.start = start_q;
		unit_ctrl.mode  = (state_q == ST_DIV_R) ? MODE_DIV : MODE_MUL;
		unique case (state_q)
			ST_MUL_P: begin
				unit_a = gain_p_q;
				unit_b = err_q;
			end
			ST_MUL_I: begin
				unit_a = gain_i_q;
				unit_b = err_q;
			end
			ST_MUL_T: begin
				unit_a = t_q;
				unit_b = dt_q;
			end
			ST_DIV_R: begin
				unit_a = diff_q;
				unit_b = dt_q;
			end
			ST_MUL_D: begin
				unit_a = gain_d_q;
				unit_b = t_q;
			end
			default: begin
				unit_a = '0;
				unit_b = '0;
			end
		endcase
	end

	pidrac_muldiv #(
		.W (W),
		.F (FRAC_BITS)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (unit_ctrl),
		.op_a   (unit_a),
		.op_b   (unit_b),
		.done   (unit_done),
		.res    (unit_res)
	);

	// exact sums before clamping
	assign integ_x = $signed({{2{integ_q[W-1]}}, integ_q}) + $signed({{2{t_q[W-1]}}, t_q});
	assign sum_x   = $signed({{2{p_q[W-1]}}, p_q}) + $signed({{2{integ_q[W-1]}}, integ_q})
		+ $signed({{2{t_q[W-1]}}, t_q});

	// limits as they stand after a limit write
	assign lo_new = (cfg_addr == REG_LIMIT_LOW)  ? cfg_wdata : lim_lo_q;
	assign hi_new = (cfg_addr == REG_LIMIT_HIGH) ? cfg_wdata : lim_hi_q;

	// configuration registers and integral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			lim_lo_q <= '0;
			lim_hi_q <= LimHighRst;
			integ_q  <= '0;
			prev_q   <= '0;
			first_q  <= 1'b1;
		end else begin
			if (accept) begin
				if (in_op == OP_RESTART) begin
					integ_q <= '0;
					prev_q  <= '0;
					first_q <= 1'b1;
				end else begin
					prev_q  <= in_measured;
					first_q <= 1'b0;
				end
			end else if (state_q == ST_INTEG) begin
				integ_q <= clamp_lim(integ_x, lim_lo_q, lim_hi_q);
			end else if (cfg_we) begin
				unique case (cfg_addr)
					REG_GAIN_P: gain_p_q <= cfg_wdata;
					REG_GAIN_I: gain_i_q <= cfg_wdata;
					REG_GAIN_D: gain_d_q <= cfg_wdata;
					REG_LIMIT_LOW, REG_LIMIT_HIGH: begin
						lim_lo_q <= lo_new;
						lim_hi_q <= hi_new;
						integ_q  <= clamp_lim({{2{integ_q[W-1]}}, integ_q}, lo_new, hi_new);
					end
					default: ;
				endcase
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			start_q   <= 1'b0;
			prime_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_op == OP_RESTART || first_q) begin
							prime_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							prime_q <= 1'b0;
							start_q <= 1'b1;
							state_q <= ST_MUL_P;
						end
					end
				end
				ST_MUL_P: begin
					if (unit_done) begin
						start_q <= 1'b1;
						state_q <= ST_MUL_I;
					end
				end
				ST_MUL_I: begin
					if (unit_done) begin
						start_q <= 1'b1;
						state_q <= ST_MUL_T;
					end
				end
				ST_MUL_T: begin
					if (unit_done) begin
						state_q <= ST_INTEG;
					end
				end
				ST_INTEG: begin
					start_q <= 1'b1;
					state_q <= ST_DIV_R;
				end
				ST_DIV_R: begin
					if (unit_done) begin
						start_q <= 1'b1;
						state_q <= ST_MUL_D;
					end
				end
				ST_MUL_D: begin
					if (unit_done) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// waits here only while an earlier result is still unread
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q  <= sat_diff(in_measured, in_target);
			diff_q <= sat_diff(in_measured, prev_q);
			dt_q   <= {1'b0, dt_fl};
		end
		if (unit_done) begin
			if (state_q == ST_MUL_P) begin
				p_q <= unit_res;
			end else begin
				t_q <= unit_res;
			end
		end
		if (state_q == ST_SUM) begin
			sum_q <= clamp_lim(sum_x, lim_lo_q, lim_hi_q);
		end
		if (state_q == ST_OUT && out_free) begin
			m_drive_q <= prime_q ? '0 : sum_q;
			m_prime_q <= prime_q;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = OutW'(m_drive_q);
	assign m_axis_tuser[0] = m_prime_q;

endmodule
